### sv/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types, codes and constants of the row set stream decoder: result
// kinds, error codes, decode phases and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package rsd_pkg;

   // Sizes
   localparam int ROW_BITS_DEFAULT  = 32;
   localparam int ROW_INDEX_W       = 32;
   localparam int DATA_W            = 8;
   localparam int KIND_W            = 2;
   localparam int ERR_W             = 3;
   localparam int RSP_TDATA_W       = 40;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int REG_IDX_W         = CSR_ADDR_W - 2;

   // Register map
   localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = '0;

   // LEB128 varint
   localparam int VINT_W       = 64;
   localparam int VINT_GROUP_W = 4;
   localparam logic [VINT_GROUP_W-1:0] VINT_LAST_GROUP   = 4'd9;
   localparam logic [DATA_W-1:0]       VINT_PAYLOAD_MASK = 8'h7F;
   localparam logic [DATA_W-1:0]       VINT_HIGH_MASK    = 8'h7E;
   localparam logic [DATA_W-1:0]       VINT_CONT_MASK    = 8'h80;

   // Record selectors
   localparam logic [DATA_W-1:0] SEL_BITMAP = 8'h00;
   localparam logic [DATA_W-1:0] SEL_LIST   = 8'h01;

   // Bitmap: eight rows per byte
   localparam int BITMAP_BYTE_SHIFT = 3;
   localparam int BITMAP_ROUND      = (1 << BITMAP_BYTE_SHIFT) - 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ROW  = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_TRUNC    = 3'd0,
      ERR_SELECTOR = 3'd1,
      ERR_RANGE    = 3'd2,
      ERR_COUNT    = 3'd3,
      ERR_ORDER    = 3'd4,
      ERR_OVERFLOW = 3'd5
   } err_type;

   // Record decode phase, one-hot
   typedef enum logic [4:0] {
      PH_START   = 5'b00001,
      PH_BITMAP  = 5'b00010,
      PH_COUNT   = 5'b00100,
      PH_DELTA   = 5'b01000,
      PH_BETWEEN = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      VINT_MORE = 2'd0,
      VINT_DONE = 2'd1,
      VINT_OVF  = 2'd2
   } vint_type;

   typedef enum logic [1:0] {
      ROW_SEL_NONE  = 2'd0,
      ROW_SEL_SCAN  = 2'd1,
      ROW_SEL_DELTA = 2'd2
   } row_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        load_in;
      logic        eob_clear;
      logic        start_bitmap;
      logic        start_count;
      logic        set_between;
      logic        set_hold;
      logic        bitmap_byte;
      logic        feed;
      logic        take_count;
      logic        calc_room;
      logic        take_delta;
      logic        scan_pop;
      logic        pend_load;
      kind_type    pend_kind;
      err_type     pend_err;
      row_sel_type pend_row_sel;
      logic        pend_last;
      logic        emit;
   } rsd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic      action;
      logic      sel_bitmap;
      logic      sel_list;
      phase_type phase;
      logic      hold;
      logic      rows_zero;
      vint_type  vint;
      logic      count_too_large;
      logic      acc_zero;
      logic      delta_range;
      logic      pos_zero;
      logic      list_ends;
      logic      mask_empty;
      logic      bit_range;
      logic      mask_rest_empty;
      logic      fin;
      logic      pend_last;
      logic      out_free;
   } rsd_status_type;

endpackage

### sv/rsd_csr.sv
// ----------------------------------------------------------------------------
// rsd_csr
// APB-style register port holding the configured row count.
// ----------------------------------------------------------------------------
module rsd_csr #(
   parameter int ROW_BITS = rsd_pkg::ROW_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [ROW_BITS-1:0]            row_count
);
   import rsd_pkg::*;

   logic [ROW_BITS-1:0]  row_count_ff;
   logic [ROW_BITS-1:0]  row_count_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 hit_row_count;
   logic                 write_en;

   // Decode the word address
   assign reg_idx       = csr_paddr[CSR_ADDR_W-1:2];
   assign hit_row_count = (reg_idx == REG_ROW_COUNT);
   assign csr_pready    = 1'b1;
   assign write_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Keep only the low row bits
   always_comb begin
      row_count_in = row_count_ff;
      if (write_en && hit_row_count) begin
         row_count_in = csr_pwdata[ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   assign csr_prdata = hit_row_count ? CSR_DATA_W'(row_count_ff) : '0;
   assign row_count  = row_count_ff;

endmodule

### sv/rsd_ctrl.sv
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer of the row set decoder: takes one beat, steps it through the
// decode checks and hands each result to the output register in order.
// ----------------------------------------------------------------------------
module rsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rsd_pkg::rsd_status_type st,
   output rsd_pkg::rsd_cmd_type    cmd
);
   import rsd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_VARINT = 7'b0000100,
      ST_DELTA  = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         // Wait for the next beat
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         // Dispatch on end of buffer, error hold and phase
         ST_DECODE: begin
            if (st.action) begin
               cmd.eob_clear = 1'b1;
               if (!st.hold && st.phase != PH_BETWEEN) begin
                  cmd.pend_load = 1'b1;
                  cmd.pend_kind = KIND_ERR;
                  cmd.pend_err  = ERR_TRUNC;
                  cmd.pend_last = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (st.hold) begin
               state_in = ST_IDLE;
            end else if (st.phase == PH_START || st.phase == PH_BETWEEN) begin
               if (st.sel_bitmap) begin
                  cmd.start_bitmap = 1'b1;
                  if (st.rows_zero) begin
                     cmd.set_between = 1'b1;
                     cmd.pend_load   = 1'b1;
                     cmd.pend_kind   = KIND_DONE;
                     cmd.pend_last   = 1'b1;
                     state_in        = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (st.sel_list) begin
                  cmd.start_count = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.set_hold  = 1'b1;
                  cmd.pend_load = 1'b1;
                  cmd.pend_kind = KIND_ERR;
                  cmd.pend_err  = ERR_SELECTOR;
                  cmd.pend_last = 1'b1;
                  state_in      = ST_EMIT;
               end
            end else if (st.phase == PH_BITMAP) begin
               cmd.bitmap_byte = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               cmd.feed = 1'b1;
               state_in = ST_VARINT;
            end
         end
         // Act on a finished or overflowed varint
         ST_VARINT: begin
            if (st.vint == VINT_OVF) begin
               cmd.set_hold  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pend_kind = KIND_ERR;
               cmd.pend_err  = ERR_OVERFLOW;
               cmd.pend_last = 1'b1;
               state_in      = ST_EMIT;
            end else if (st.vint != VINT_DONE) begin
               state_in = ST_IDLE;
            end else if (st.phase == PH_COUNT) begin
               if (st.count_too_large) begin
                  cmd.set_hold  = 1'b1;
                  cmd.pend_load = 1'b1;
                  cmd.pend_kind = KIND_ERR;
                  cmd.pend_err  = ERR_COUNT;
                  cmd.pend_last = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  cmd.take_count = 1'b1;
                  if (st.acc_zero) begin
                     cmd.set_between = 1'b1;
                     cmd.pend_load   = 1'b1;
                     cmd.pend_kind   = KIND_DONE;
                     cmd.pend_last   = 1'b1;
                     state_in        = ST_EMIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.calc_room = 1'b1;
               state_in      = ST_DELTA;
            end
         end
         // Check the delta, then emit its row or a range or order error
         ST_DELTA: begin
            if (st.delta_range) begin
               cmd.set_hold  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pend_kind = KIND_ERR;
               cmd.pend_err  = ERR_RANGE;
               cmd.pend_last = 1'b1;
            end else if (!st.pos_zero && st.acc_zero) begin
               cmd.set_hold  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pend_kind = KIND_ERR;
               cmd.pend_err  = ERR_ORDER;
               cmd.pend_last = 1'b1;
            end else begin
               cmd.take_delta   = 1'b1;
               cmd.pend_load    = 1'b1;
               cmd.pend_kind    = KIND_ROW;
               cmd.pend_row_sel = ROW_SEL_DELTA;
               cmd.pend_last    = !st.list_ends;
            end
            state_in = ST_EMIT;
         end
         // Walk the set bits of a bitmap byte, lowest first
         ST_SCAN: begin
            if (st.mask_empty) begin
               if (st.fin) begin
                  cmd.set_between = 1'b1;
                  cmd.pend_load   = 1'b1;
                  cmd.pend_kind   = KIND_DONE;
                  cmd.pend_last   = 1'b1;
                  state_in        = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (st.bit_range) begin
               cmd.set_hold  = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pend_kind = KIND_ERR;
               cmd.pend_err  = ERR_RANGE;
               cmd.pend_last = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.scan_pop     = 1'b1;
               cmd.pend_load    = 1'b1;
               cmd.pend_kind    = KIND_ROW;
               cmd.pend_row_sel = ROW_SEL_SCAN;
               cmd.pend_last    = st.mask_rest_empty && !st.fin;
               state_in         = ST_EMIT;
            end
         end
         // Close a list record after its last row
         ST_FINISH: begin
            cmd.set_between = 1'b1;
            cmd.pend_load   = 1'b1;
            cmd.pend_kind   = KIND_DONE;
            cmd.pend_last   = 1'b1;
            state_in        = ST_EMIT;
         end
         // Move the pending result into the output register
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.pend_last) begin
                  state_in = ST_IDLE;
               end else if (st.phase == PH_BITMAP) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/rsd_datapath.sv
// ----------------------------------------------------------------------------
// rsd_datapath
// Decode state of the row set decoder: varint accumulator, list counters,
// bitmap byte walker, range checks, pending result and output register.
// ----------------------------------------------------------------------------
module rsd_datapath #(
   parameter int ROW_BITS = rsd_pkg::ROW_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rsd_pkg::rsd_cmd_type            cmd,
   output rsd_pkg::rsd_status_type         st,
   input  logic [ROW_BITS-1:0]             row_count,
   input  logic [rsd_pkg::DATA_W-1:0]      req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [rsd_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                            rsp_tlast
);
   import rsd_pkg::*;

   localparam int IDX_W = ROW_BITS - BITMAP_BYTE_SHIFT;

   // Input beat
   logic              in_action_ff;
   logic [DATA_W-1:0] in_byte_ff;

   // Record state
   phase_type phase_ff, phase_in;
   logic      hold_ff, hold_in;

   // Varint
   logic [VINT_W-1:0]       acc_ff;
   logic [VINT_GROUP_W-1:0] group_ff;
   vint_type                vint_ff;
   logic [6:0]              vint_shift;
   logic [VINT_W-1:0]       vint_bits;
   logic                    vint_ovf;
   logic                    vint_cont;
   logic                    vint_clear;

   // List
   logic [ROW_BITS-1:0] list_count_ff;
   logic [ROW_BITS-1:0] list_pos_ff;
   logic [ROW_BITS-1:0] prev_row_ff;
   logic                list_ends_ff;
   logic [ROW_BITS:0]   pos_next;
   logic [ROW_BITS:0]   room_ff;
   logic [ROW_BITS:0]   room_in;
   logic [ROW_BITS:0]   rc_ext;
   logic [VINT_W-1:0]   room_wide;
   logic [ROW_BITS-1:0] acc_lo;
   logic [ROW_BITS-1:0] delta_row;
   logic                pos_zero;

   // Bitmap
   logic [IDX_W-1:0]          byte_index_ff;
   logic [IDX_W-1:0]          base_ff;
   logic [DATA_W-1:0]         mask_ff;
   logic                      fin_ff;
   logic [ROW_BITS:0]         nbytes_sum;
   logic [IDX_W:0]            nbytes;
   logic [IDX_W:0]            idx_next;
   logic [DATA_W-1:0]         low_onehot;
   logic [DATA_W-1:0]         mask_rest;
   logic [BITMAP_BYTE_SHIFT-1:0] bit_pos;
   logic [ROW_BITS-1:0]       scan_row;

   // Pending result and output register
   kind_type            pend_kind_ff;
   err_type             pend_err_ff;
   logic [ROW_BITS-1:0] pend_row_ff;
   logic [ROW_BITS-1:0] pend_row_in;
   logic                pend_last_ff;
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   err_type             rsp_err_ff;
   logic [ROW_INDEX_W-1:0] rsp_row_ff;
   logic                rsp_last_ff;

   // Varint group: OR seven payload bits in at 7 * group
   assign vint_shift = {group_ff, 3'b000} - {3'b000, group_ff};
   assign vint_bits  = VINT_W'(in_byte_ff & VINT_PAYLOAD_MASK) << vint_shift;
   assign vint_cont  = (in_byte_ff & VINT_CONT_MASK) != '0;
   assign vint_ovf   = (group_ff == VINT_LAST_GROUP) &&
                       ((in_byte_ff & (VINT_HIGH_MASK | VINT_CONT_MASK)) != '0);
   assign vint_clear = cmd.eob_clear | cmd.start_count | cmd.take_count | cmd.take_delta;

   // List checks
   assign rc_ext    = {1'b0, row_count};
   assign acc_lo    = acc_ff[ROW_BITS-1:0];
   assign pos_zero  = (list_pos_ff == '0);
   assign pos_next  = {1'b0, list_pos_ff} + (ROW_BITS+1)'(1);
   assign room_in   = pos_zero ? rc_ext : rc_ext - {1'b0, prev_row_ff};
   // Room as a 64-bit difference: sign-extend the narrow one
   assign room_wide = {{(VINT_W-ROW_BITS-1){room_ff[ROW_BITS]}}, room_ff};
   assign delta_row = pos_zero ? acc_lo : prev_row_ff + acc_lo;

   // Bitmap byte count and lowest set bit
   assign nbytes_sum = rc_ext + (ROW_BITS+1)'(BITMAP_ROUND);
   assign nbytes     = nbytes_sum[ROW_BITS:BITMAP_BYTE_SHIFT];
   assign idx_next   = {1'b0, byte_index_ff} + (IDX_W+1)'(1);
   assign low_onehot = mask_ff & (~mask_ff + DATA_W'(1));
   assign mask_rest  = mask_ff & ~low_onehot;
   assign scan_row   = {base_ff, bit_pos};

   always_comb begin
      bit_pos = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (low_onehot[i]) begin
            bit_pos = BITMAP_BYTE_SHIFT'(i);
         end
      end
   end

   // Phase and error hold
   always_comb begin
      phase_in = phase_ff;
      priority if (cmd.eob_clear) begin
         phase_in = PH_START;
      end else if (cmd.set_between) begin
         phase_in = PH_BETWEEN;
      end else if (cmd.start_bitmap) begin
         phase_in = PH_BITMAP;
      end else if (cmd.start_count) begin
         phase_in = PH_COUNT;
      end else if (cmd.take_count) begin
         phase_in = PH_DELTA;
      end else begin
         phase_in = phase_ff;
      end
      hold_in = hold_ff;
      if (cmd.eob_clear) begin
         hold_in = 1'b0;
      end else if (cmd.set_hold) begin
         hold_in = 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.pend_row_sel)
         ROW_SEL_SCAN:  pend_row_in = scan_row;
         ROW_SEL_DELTA: pend_row_in = delta_row;
         default:       pend_row_in = '0;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
      // Varint accumulate or restart
      if (vint_clear) begin
         acc_ff   <= '0;
         group_ff <= '0;
      end else if (cmd.feed) begin
         if (!vint_ovf) begin
            acc_ff <= acc_ff | vint_bits;
            if (vint_cont) begin
               group_ff <= group_ff + VINT_GROUP_W'(1);
            end
         end
      end
      if (cmd.feed) begin
         vint_ff      <= vint_ovf ? VINT_OVF : (vint_cont ? VINT_MORE : VINT_DONE);
         list_ends_ff <= (pos_next >= {1'b0, list_count_ff});
      end
      // List counters
      if (cmd.eob_clear) begin
         list_count_ff <= '0;
         list_pos_ff   <= '0;
         prev_row_ff   <= '0;
      end else if (cmd.take_count) begin
         list_count_ff <= acc_lo;
         list_pos_ff   <= '0;
         prev_row_ff   <= '0;
      end else if (cmd.take_delta) begin
         list_pos_ff <= pos_next[ROW_BITS-1:0];
         prev_row_ff <= delta_row;
      end
      if (cmd.calc_room) begin
         room_ff <= room_in;
      end
      // Bitmap walker
      if (cmd.eob_clear || cmd.start_bitmap) begin
         byte_index_ff <= '0;
      end else if (cmd.bitmap_byte) begin
         byte_index_ff <= idx_next[IDX_W-1:0];
      end
      if (cmd.bitmap_byte) begin
         base_ff <= byte_index_ff;
         mask_ff <= in_byte_ff;
         fin_ff  <= (idx_next >= nbytes);
      end else if (cmd.scan_pop) begin
         mask_ff <= mask_rest;
      end
      // Pending result
      if (cmd.pend_load) begin
         pend_kind_ff <= cmd.pend_kind;
         pend_err_ff  <= (cmd.pend_kind == KIND_ERR) ? cmd.pend_err : ERR_TRUNC;
         pend_row_ff  <= pend_row_in;
         pend_last_ff <= cmd.pend_last;
      end
      // Output register
      if (cmd.emit) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_err_ff  <= pend_err_ff;
         rsp_row_ff  <= ROW_INDEX_W'(pend_row_ff);
         rsp_last_ff <= pend_last_ff;
      end
   end

   // Status back to the controller
   always_comb begin
      st                 = '0;
      st.action          = in_action_ff;
      st.sel_bitmap      = (in_byte_ff == SEL_BITMAP);
      st.sel_list        = (in_byte_ff == SEL_LIST);
      st.phase           = phase_ff;
      st.hold            = hold_ff;
      st.rows_zero       = (row_count == '0);
      st.vint            = vint_ff;
      st.count_too_large = (acc_ff[VINT_W-1:ROW_BITS] != '0) || (acc_lo > row_count);
      st.acc_zero        = (acc_ff == '0);
      st.delta_range     = (acc_ff >= room_wide);
      st.pos_zero        = pos_zero;
      st.list_ends       = list_ends_ff;
      st.mask_empty      = (mask_ff == '0);
      st.bit_range       = (scan_row >= row_count);
      st.mask_rest_empty = (mask_rest == '0);
      st.fin             = fin_ff;
      st.pend_last       = pend_last_ff;
      st.out_free        = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_err_ff, rsp_row_ff});
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/rowset_stream_decoder.sv
// ----------------------------------------------------------------------------
// rowset_stream_decoder
// Row set decoder: bitmap or LEB128 delta list records, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one encoded byte (tuser low) or an end-of-buffer mark (tuser high) per
// input beat and emits row indices, a record-complete mark and error codes,
// with tlast on the final result of each input beat. The beat is processed by
// a sequencer; one beat is in flight at a time. Each beat is registered, then
// dispatched: a count or delta byte goes on through the varint step, a final
// delta byte also through the delta check, and a bitmap byte is walked one set
// bit at a time, lowest first. Each result passes through an emit step; the
// last bitmap byte and the last delta of a list also yield the record-complete
// mark. Every result waits in a pending register and moves into the output
// register when that slot is free, so stalls on the result side hold the
// sequencer. Row count is set through the register port at offset 0 and must
// not change while a beat is in work.
// ----------------------------------------------------------------------------
module rowset_stream_decoder #(
   parameter int ROW_BITS = rsd_pkg::ROW_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Encoded input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rsd_pkg::DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                            req_tuser,   // [0] action
   // Results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] row_index, [34:32] error_code
   output logic [rsd_pkg::KIND_W-1:0]      rsp_tuser,   // [1:0] kind
   output logic                            rsp_tlast,
   // Register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rsd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rsd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rsd_pkg::*;

   logic [ROW_BITS-1:0] row_count;
   rsd_cmd_type         cmd;
   rsd_status_type      st;

   rsd_csr #(
      .ROW_BITS (ROW_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_count   (row_count)
   );

   rsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   rsd_datapath #(
      .ROW_BITS (ROW_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .row_count  (row_count),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
